// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ACS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression that must never be true outside reset
`define ACS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/acs_pkg.sv =====
// ---------------------------------------------------------------------------
// acs_pkg
// shared types and constants of the accumulator machine step block
// ---------------------------------------------------------------------------
package acs_pkg;

  localparam int MEM_WORDS = 128;
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int PLEN_W    = ADDR_W + 1;
  localparam int WORD_W    = 16;
  localparam int PC_W      = 7;
  localparam int OPND_W    = 7;
  localparam int OPC_W     = 3;
  localparam int OPC_LSB   = 7;
  localparam int BP_POS    = 15;
  localparam int DSUM_W    = PLEN_W + 1;

  typedef enum logic [1:0] {
    REQ_BEGIN = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_BREAK = 2'd2,
    REQ_EXEC  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BREAK = 2'd1,
    STAT_END   = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [OPC_W-1:0] {
    OP_NOP   = 3'd0,
    OP_READ  = 3'd1,
    OP_WRITE = 3'd2,
    OP_ADD   = 3'd3,
    OP_SUB   = 3'd4,
    OP_JMP   = 3'd5,
    OP_SET   = 3'd6,
    OP_END   = 3'd7
  } opc_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_t           status;
    logic [PC_W-1:0]   pc;
    logic [WORD_W-1:0] mbr;
    logic [OPND_W-1:0] mar;
    logic [WORD_W-1:0] ir;
  } res_t;

endpackage

// ===== rtl/acs_mem.sv =====
// ---------------------------------------------------------------------------
// acs_mem
// program and data memory, one write and one registered read per cycle,
// entries never written read as zero
// ---------------------------------------------------------------------------
module acs_mem
  import acs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mem_req_t          req,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0]    mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] valid_r;
  logic [WORD_W-1:0]    rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= valid_r[req.raddr] ? mem[req.raddr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[req.waddr] <= 1'b1;
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/acs_core.sv =====
// ---------------------------------------------------------------------------
// acs_core
// request sequencer and machine registers: accept/fetch, decode/access,
// accumulate/retire, with retire overlapping the next accept
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module acs_core
  import acs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  req_t              in_req,
  input  logic [WORD_W-1:0] in_word,
  input  logic [PC_W-1:0]   in_bp_address,
  output mem_req_t          mem_req,
  input  logic [WORD_W-1:0] mem_rdata,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  logic              busy_b_r, busy_b_nxt;
  logic              busy_c_r, busy_c_nxt;
  req_t              req_r, req_nxt;
  opc_t              opc_r, opc_nxt;
  logic [ADDR_W-1:0] bpa_r, bpa_nxt;
  status_t           status_r, status_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [WORD_W-1:0] mbr_r, mbr_nxt;
  logic [OPND_W-1:0] mar_r, mar_nxt;
  logic [WORD_W-1:0] ir_r, ir_nxt;
  logic [PLEN_W-1:0] plen_r, plen_nxt;

  logic              in_fire;
  logic              c_done;
  opc_t              dec_opc;
  logic [OPND_W-1:0] dec_opnd;
  logic [DSUM_W-1:0] dsum;
  logic [ADDR_W-1:0] daddr;

  assign c_done   = busy_c_r && res_ready;
  assign in_ready = !busy_b_r && (!busy_c_r || res_ready);
  assign in_fire  = in_valid && in_ready;

  assign dec_opc  = opc_t'(mem_rdata[OPC_LSB +: OPC_W]);
  assign dec_opnd = mem_rdata[OPND_W-1:0];
  assign dsum     = DSUM_W'(dec_opnd) + DSUM_W'(plen_r);
  assign daddr    = dsum[ADDR_W-1:0];

  always_comb begin
    busy_b_nxt = busy_b_r;
    busy_c_nxt = busy_c_r;
    req_nxt    = req_r;
    opc_nxt    = opc_r;
    bpa_nxt    = bpa_r;
    status_nxt = status_r;
    pc_nxt     = pc_r;
    mbr_nxt    = mbr_r;
    mar_nxt    = mar_r;
    ir_nxt     = ir_r;
    plen_nxt   = plen_r;
    mem_req    = '0;

    // accumulate and retire
    if (c_done) begin
      busy_c_nxt = 1'b0;
      if (req_r == REQ_EXEC) begin
        unique case (opc_r)
          OP_READ: mbr_nxt = mem_rdata;
          OP_ADD:  mbr_nxt = mbr_r + mem_rdata;
          OP_SUB:  mbr_nxt = mbr_r - mem_rdata;
          default: mbr_nxt = mbr_r;
        endcase
      end
    end

    // decode and data access
    if (busy_b_r) begin
      busy_b_nxt = 1'b0;
      busy_c_nxt = 1'b1;
      unique case (req_r)
        REQ_BREAK: begin
          mem_req.we    = 1'b1;
          mem_req.waddr = bpa_r;
          mem_req.wdata = mem_rdata | (WORD_W'(1) << BP_POS);
        end
        REQ_EXEC: begin
          ir_nxt  = mem_rdata;
          opc_nxt = dec_opc;
          unique case (dec_opc)
            OP_READ, OP_ADD, OP_SUB: begin
              mar_nxt       = dec_opnd;
              mem_req.re    = 1'b1;
              mem_req.raddr = daddr;
            end
            OP_WRITE: begin
              mar_nxt       = dec_opnd;
              mem_req.we    = 1'b1;
              mem_req.waddr = daddr;
              mem_req.wdata = {{(WORD_W-OPND_W){1'b0}}, mbr_r[OPND_W-1:0]};
            end
            OP_SET:  mbr_nxt = WORD_W'(dec_opnd);
            default: ;
          endcase
          unique case (dec_opc)
            OP_JMP:  pc_nxt = dec_opnd;
            OP_END:  pc_nxt = pc_r;
            default: pc_nxt = pc_r + PC_W'(1);
          endcase
          if (mem_rdata[BP_POS]) begin
            status_nxt = STAT_BREAK;
          end else if (dec_opc == OP_END) begin
            status_nxt = STAT_END;
          end else begin
            status_nxt = STAT_OK;
          end
        end
        default: ;
      endcase
    end

    // accept, and fetch or write the load word
    if (in_fire) begin
      busy_b_nxt = 1'b1;
      req_nxt    = in_req;
      bpa_nxt    = in_bp_address[ADDR_W-1:0];
      status_nxt = STAT_OK;
      unique case (in_req)
        REQ_BEGIN: begin
          pc_nxt   = '0;
          plen_nxt = '0;
        end
        REQ_LOAD: begin
          if (plen_r < PLEN_W'(MEM_WORDS)) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = plen_r[ADDR_W-1:0];
            mem_req.wdata = in_word;
            plen_nxt      = plen_r + PLEN_W'(1);
          end else begin
            status_nxt = STAT_FULL;
          end
        end
        REQ_BREAK: begin
          mem_req.re    = 1'b1;
          mem_req.raddr = in_bp_address[ADDR_W-1:0];
        end
        REQ_EXEC: begin
          mem_req.re    = 1'b1;
          mem_req.raddr = pc_r[ADDR_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_b_r <= 1'b0;
      busy_c_r <= 1'b0;
      pc_r     <= '0;
      mbr_r    <= '0;
      mar_r    <= '0;
      ir_r     <= '0;
      plen_r   <= '0;
    end else begin
      busy_b_r <= busy_b_nxt;
      busy_c_r <= busy_c_nxt;
      pc_r     <= pc_nxt;
      mbr_r    <= mbr_nxt;
      mar_r    <= mar_nxt;
      ir_r     <= ir_nxt;
      plen_r   <= plen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    opc_r    <= opc_nxt;
    bpa_r    <= bpa_nxt;
    status_r <= status_nxt;
  end

  assign res_valid  = busy_c_r;
  assign res.status = status_r;
  assign res.pc     = pc_r;
  assign res.mbr    = mbr_nxt;
  assign res.mar    = mar_r;
  assign res.ir     = ir_r;

  `ACS_ASSERT_NEVER(a_phase_overlap, busy_b_r && busy_c_r, "decode and retire overlap")
  `ACS_ASSERT(a_b_to_c, busy_b_r |=> busy_c_r, "decoded request did not reach retire")
  `ACS_ASSERT(a_retire_hold, busy_c_r && !res_ready |=> busy_c_r && $stable(mbr_r), "stalled retire lost")
  `ACS_ASSERT(a_accept_free, in_fire |-> !busy_b_r, "accept while decode busy")

endmodule

// ===== rtl/acs_out.sv =====
// ---------------------------------------------------------------------------
// acs_out
// result register in front of the master-side stream
// ---------------------------------------------------------------------------
module acs_out
  import acs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid,
  output logic        res_ready,
  input  res_t        res,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  output logic [1:0]  out_tuser
);

  logic out_valid_r, out_valid_nxt;
  res_t res_r;

  assign res_ready     = !out_valid_r || out_tready;
  assign out_valid_nxt = res_valid || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {2'b00, res_r.ir, res_r.mar, res_r.mbr, res_r.pc};

endmodule

// ===== rtl/accumulator_cpu_step.sv =====
// ---------------------------------------------------------------------------
// accumulator_cpu_step
// one request per transaction on a tiny accumulator machine with a
// 128-word program and data memory
//
// slave side: in_tuser carries the request kind (begin load, load word,
// set breakpoint, execute one instruction), in_tdata the load word and the
// breakpoint address. master side: one result per request, out_tuser the
// status, out_tdata the registers after the request.
// a request passes fetch, decode and retire before out_tvalid; no new
// request is taken while one is in decode, since the single memory port
// serves the instruction fetch in one cycle and the data access in the next.
// reset clears pc, mbr, mar, ir and program length; the memory reads as
// zero until each word is written, so no clearing pass is needed.
// when the receiver stalls, one finished result waits in the output
// register and one more in the retire stage; then in_tready falls.
// ---------------------------------------------------------------------------
module accumulator_cpu_step
  import acs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // word[15:0], bp_address[22:16], zero[23]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // pc_out[6:0], mbr_out[22:7], mar_out[29:23],
                                  // ir_out[45:30], zero[47:46]
  output logic [1:0]  out_tuser   // status[1:0]
);

  mem_req_t          mem_req;
  logic [WORD_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  acs_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  acs_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_req        (req_t'(in_tuser)),
    .in_word       (in_tdata[15:0]),
    .in_bp_address (in_tdata[22:16]),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  acs_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
